FILE: hdl/ctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and constants of the compact target retarget unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ctr_pkg;

    localparam int unsigned SPAN_W     = 24;
    localparam int unsigned TS_W       = 26;
    localparam int unsigned BASE_W     = 23;
    localparam int unsigned PROD_W     = BASE_W + TS_W;
    localparam int unsigned MAX_PAD    = 5;
    localparam int unsigned DIV_W      = PROD_W + 8 * MAX_PAD;
    localparam int unsigned QBYTES     = (DIV_W + 7) / 8;
    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(14 * 24 * 60 * 60);

    typedef struct packed {
        logic [31:0] previous_bits;
        logic signed [31:0] actual_timespan;
    } ctr_cmd_t;

    typedef struct packed {
        logic [31:0] next_bits;
        logic        overflow;
    } ctr_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [7:0]        ext;
        logic [SPAN_W-1:0] rem;
        logic [DIV_W-1:0]  word;
    } ctr_lane_t;

endpackage

`default_nettype wire

FILE: hdl/compact_target_retarget_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_target_retarget_unit
// Scales a compact difficulty word by a clamped timespan over a nominal period.
// ----------------------------------------------------------------------------
// usage:
//   an item is taken at a clock edge with start high and busy low; cmd holds
//   previous_bits and actual_timespan
//   the result appears on rsp for one cycle with done high once the item has
//   passed the front registers, the division cells and the output register;
//   the receiver cannot stall it; one item per cycle, back to back, while
//   busy is low, through a row of one-bit division cells, one per dividend bit
//   target_timespan is written over cfg_valid / cfg_ready / cfg_data; the user
//   must write it only while no item is in flight, which the block itself does not enforce; cfg_ready is !busy
//   reset clears the pipeline and loads the nominal period of two weeks;
//   busy is high only during reset and the cycle after it
// ----------------------------------------------------------------------------
`default_nettype none

module compact_target_retarget_unit
    import ctr_pkg::*;
#(
    parameter int unsigned TARGET_BYTES = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ctr_cmd_t          cmd,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [SPAN_W-1:0] cfg_data,
    output logic                   done,
    output ctr_rsp_t               rsp
);

    logic              busy_reg;
    logic [SPAN_W-1:0] span_reg;
    ctr_lane_t         lanes [DIV_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            span_reg <= SPAN_RESET;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
                span_reg <= cfg_data;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;

    ctr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (start && !busy_reg),
        .cmd   (cmd),
        .span  (span_reg),
        .lane  (lanes[0])
    );

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_cell
        ctr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .span     (span_reg),
            .lane_in  (lanes[i]),
            .lane_out (lanes[i+1])
        );
    end

    ctr_encode #(
        .TARGET_BYTES (TARGET_BYTES)
    ) u_encode (
        .clk   (clk),
        .rst_n (rst_n),
        .span  (span_reg),
        .lane  (lanes[DIV_W]),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

FILE: hdl/ctr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_front
// Clamps the timespan, decodes the compact word, multiplies and aligns.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_front
    import ctr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire ctr_cmd_t          cmd,
    input  wire logic [SPAN_W-1:0] span,
    output ctr_lane_t              lane
);

    logic              v1_reg;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [BASE_W-1:0] base_reg, base_next;
    logic [2:0]        sh_reg, sh_next;
    logic [7:0]        ext_reg, ext_next;
    logic              v2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [2:0]        sh2_reg;
    logic [7:0]        ext2_reg;

    logic signed [32:0] act;
    logic signed [32:0] lo;
    logic signed [32:0] hi;
    logic [7:0]         sz;
    logic [22:0]        mant;
    logic [7:0]         z;

    always_comb
    begin
        act  = {cmd.actual_timespan[31], cmd.actual_timespan};
        lo   = 33'({2'b00, span} >> 2);
        hi   = 33'({2'b00, span} << 2);
        sz   = cmd.previous_bits[31:24];
        mant = cmd.previous_bits[22:0];
        if (act < lo)
            ts_next = TS_W'(lo);
        else if (act > hi)
            ts_next = TS_W'(hi);
        else
            ts_next = TS_W'(act);
        if (sz == 8'd0)
            base_next = '0;
        else if (sz == 8'd1)
            base_next = mant >> 16;
        else if (sz == 8'd2)
            base_next = mant >> 8;
        else
            base_next = mant;
        z = (sz > 8'd3) ? sz - 8'd3 : 8'd0;
        if (z > 8'(MAX_PAD))
        begin
            sh_next  = 3'(MAX_PAD);
            ext_next = z - 8'(MAX_PAD);
        end
        else
        begin
            sh_next  = z[2:0];
            ext_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg   <= ts_next;
        base_reg <= base_next;
        sh_reg   <= sh_next;
        ext_reg  <= ext_next;
        prod_reg <= PROD_W'(base_reg * ts_reg);
        sh2_reg  <= sh_reg;
        ext2_reg <= ext_reg;
    end

    always_comb
    begin
        lane.valid = v2_reg;
        lane.ext   = ext2_reg;
        lane.rem   = '0;
        lane.word  = DIV_W'(prod_reg) << {sh2_reg, 3'b000};
    end

endmodule

`default_nettype wire

FILE: hdl/ctr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_cell
// One restoring division step: shifts in a dividend bit, emits a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_cell
    import ctr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SPAN_W-1:0] span,
    input  wire ctr_lane_t         lane_in,
    output ctr_lane_t              lane_out
);

    logic            valid_reg;
    ctr_lane_t       data_reg, data_next;
    logic [SPAN_W:0] cur;
    logic            q;

    always_comb
    begin
        cur             = {lane_in.rem, lane_in.word[DIV_W-1]};
        q               = (cur >= {1'b0, span});
        data_next       = lane_in;
        data_next.rem   = q ? SPAN_W'(cur - {1'b0, span}) : SPAN_W'(cur);
        data_next.word  = {lane_in.word[DIV_W-2:0], q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= lane_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        lane_out       = data_reg;
        lane_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/ctr_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_encode
// Finds the quotient byte length and packs the new compact word.
// ----------------------------------------------------------------------------
`default_nettype none

module ctr_encode
    import ctr_pkg::*;
#(
    parameter int unsigned TARGET_BYTES = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SPAN_W-1:0] span,
    input  wire ctr_lane_t         lane,
    output logic                   done,
    output ctr_rsp_t               rsp
);

    logic     done_reg;
    ctr_rsp_t rsp_reg, rsp_next;

    logic [8*QBYTES-1:0]    qw;
    logic [8*QBYTES+23:0]   xw;
    logic [3:0]             nb;
    logic [8:0]             len;
    logic [23:0]            top;

    always_comb
    begin
        qw = (8*QBYTES)'(lane.word);
        xw = {qw, 24'h000000};
        nb = '0;
        for (int b = 0; b < QBYTES; b++)
        begin
            if (qw[8*b +: 8] != 8'h00)
                nb = 4'(b + 1);
        end
        top = xw[{nb, 3'b000} +: 24];
        len = 9'(lane.ext) + 9'(nb);
        rsp_next = '0;
        if (span == '0 || nb == '0)
            rsp_next = '0;
        else if (len > 9'(TARGET_BYTES))
            rsp_next.overflow = 1'b1;
        else if (top[23])
            rsp_next.next_bits = {8'h01, len[7:0], top[23:8]};
        else
            rsp_next.next_bits = {len[7:0], top};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= lane.valid;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the compact target retarget unit against a behavioral predictor:
// directed corner items, a sweep of nominal periods and random bursts, each
// result compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import ctr_pkg::*;
();

    localparam int unsigned TARGET_BYTES = 32;
    localparam int unsigned LATENCY      = DIV_W + 3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    ctr_cmd_t          cmd;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SPAN_W-1:0] cfg_data;
    logic              done;
    ctr_rsp_t          rsp;

    logic [SPAN_W-1:0] period;
    ctr_rsp_t          expected_words[$];
    int                errors;

    compact_target_retarget_unit #(.TARGET_BYTES(TARGET_BYTES)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic ctr_rsp_t retarget(logic [31:0] bits, logic signed [31:0] span,
                                          logic [SPAN_W-1:0] nominal);
        ctr_rsp_t     r;
        longint       act;
        longint       lo;
        longint       hi;
        longint       clamped;
        int unsigned  nbytes;
        int unsigned  pad;
        int unsigned  total;
        int unsigned  len;
        int unsigned  ntop;
        logic [63:0]  base;
        logic [63:0]  prod;
        logic [63:0]  rem;
        logic [63:0]  cur;
        logic [63:0]  q;
        logic [7:0]   digit;
        logic [7:0]   top [3];
        logic [31:0]  word;
        bit           found;
        r = '0;
        if (nominal == 0)
            return r;
        act = longint'(span);
        lo = longint'(nominal) / 4;
        hi = longint'(nominal) * 4;
        clamped = (act < lo) ? lo : (act > hi) ? hi : act;
        nbytes = bits[31:24];
        if (nbytes == 0)
            base = 0;
        else if (nbytes < 3)
            base = 64'(bits[22:0]) >> (8 * (3 - nbytes));
        else
            base = 64'(bits[22:0]);
        pad = (nbytes > 3) ? nbytes - 3 : 0;
        prod = base * 64'(clamped);
        total = 7 + pad;
        rem = 0;
        len = 0;
        ntop = 0;
        found = 0;
        top[0] = 0;
        top[1] = 0;
        top[2] = 0;
        for (int unsigned i = 0; i < total; i++)
        begin
            digit = (i < 7) ? prod[8*(6-i) +: 8] : 8'h00;
            cur = rem * 256 + 64'(digit);
            q = cur / 64'(nominal);
            rem = cur % 64'(nominal);
            if (!found && q != 0)
            begin
                found = 1;
                len = total - i;
            end
            if (found && ntop < 3)
            begin
                top[ntop] = q[7:0];
                ntop++;
            end
        end
        if (!found)
            return r;
        if (len > TARGET_BYTES)
        begin
            r.overflow = 1'b1;
            return r;
        end
        word = {len[7:0], top[0], top[1], top[2]};
        if (word[23])
            word = (word >> 8) + 32'h0100_0000;
        r.next_bits = word;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        ctr_rsp_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                report("unexpected item", rsp.next_bits, 32'h0);
            else
            begin
                want = expected_words.pop_front();
                if (rsp.next_bits !== want.next_bits)
                    report("next_bits", rsp.next_bits, want.next_bits);
                if (rsp.overflow !== want.overflow)
                    report("overflow", 32'(rsp.overflow), 32'(want.overflow));
            end
        end
    end

    task automatic send_item(logic [31:0] bits, logic [31:0] span);
        @(negedge clk);
        start = 1'b1;
        cmd.previous_bits = bits;
        cmd.actual_timespan = span;
        do @(posedge clk); while (busy);
        expected_words = {expected_words, retarget(bits, span, period)};
    endtask

    task automatic pause(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start = 1'b0;
            cmd = ctr_cmd_t'({$urandom, $urandom});
        end
    endtask

    task automatic drain();
        pause(1);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_period(logic [SPAN_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        period = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] random_bits();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 9))
            0:       b[31:24] = 8'($urandom_range(0, 3));
            1:       b[31:24] = 8'($urandom);
            2:       b[31:24] = 8'($urandom_range(28, 40));
            default: b[31:24] = 8'($urandom_range(3, 34));
        endcase
        return b;
    endfunction

    function automatic logic [31:0] random_span();
        longint p;
        p = longint'(period);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'(-$signed(32'($urandom_range(0, 1000))));
            2:       return 32'(p / 4 + $urandom_range(0, 2) - 1);
            3:       return 32'(p * 4 + $urandom_range(0, 2) - 1);
            default: return 32'(p / 4 + longint'($urandom) % (p * 4 - p / 4 + 1));
        endcase
    endfunction

    task automatic random_burst(int unsigned count);
        int unsigned left;
        int unsigned run;
        left = count;
        while (left > 0)
        begin
            run = $urandom_range(1, 40);
            if (run > left)
                run = left;
            for (int unsigned i = 0; i < run; i++)
                send_item(random_bits(), random_span());
            left -= run;
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    task automatic test_directed();
        send_item(32'h1d00_ffff, 32'sd1209600);
        send_item(32'h0000_0000, 32'sd1209600);
        send_item(32'h0012_3456, 32'sd1209600);
        send_item(32'h0112_3456, 32'sd1209600);
        send_item(32'h0212_3456, 32'sd1209600);
        send_item(32'h0380_0000, 32'sd1209600);
        send_item(32'h03ff_ffff, 32'sd1209600);
        send_item(32'h1d7f_ffff, 32'h7fff_ffff);
        send_item(32'h1d7f_ffff, 32'h8000_0000);
        send_item(32'h1d00_ffff, 32'sd302400);
        send_item(32'h1d00_ffff, 32'sd4838400);
        send_item(32'h1d00_ffff, 32'sd302399);
        send_item(32'h1d00_ffff, 32'sd4838401);
        send_item(32'h207f_ffff, 32'sd4838400);
        send_item(32'h2000_0001, 32'sd1209600);
        send_item(32'h2100_0001, 32'sd1209600);
        send_item(32'hff7f_ffff, 32'sd1209600);
        send_item(32'h0400_8000, 32'sd1209601);
        send_item(32'h0300_0001, 32'sd302400);
        send_item(32'hffff_ffff, 32'hffff_ffff);
        send_item(32'h0100_0000, 32'sd0);
        send_item(32'h1b04_04cb, 32'sd1209599);
    endtask

    task automatic test_period_sweep();
        logic [SPAN_W-1:0] periods [10];
        periods = '{24'd4, 24'hff_ffff, 24'd0, 24'd1, 24'd3, 24'd5, 24'd1000,
                    24'd600, 24'h80_0000, 24'd1209600};
        foreach (periods[k])
        begin
            write_period(periods[k]);
            send_item(32'h1d00_ffff, 32'h7fff_ffff);
            send_item(32'h1d7f_ffff, 32'h8000_0000);
            random_burst(60);
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 6; k++)
        begin
            write_period((k % 2) ? 24'($urandom_range(4, 5000)) : 24'($urandom));
            random_burst(200);
        end
        write_period(SPAN_RESET);
        random_burst(100);
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        period = SPAN_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_period_sweep();
        test_random();
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
